// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Widths, surrogate constants and the result record shared by the design.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned OwedW  = 2;

  // Code point limits.
  localparam logic [PointW-1:0] SurrLo    = 21'h00_D800;
  localparam logic [PointW-1:0] SurrHi    = 21'h00_DFFF;
  localparam logic [PointW-1:0] SuppBase  = 21'h01_0000;
  localparam logic [PointW-1:0] PointMax  = 21'h10_FFFF;

  // Top six bits of the high and low surrogate units.
  localparam logic [5:0] HiSurrTag = 6'b110110;
  localparam logic [5:0] LoSurrTag = 6'b110111;

  // Lead byte prefixes.
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  // One result item.
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             is_terminator;
    logic             bad_code_point;
    logic             last_of_run;
  } result_t;

endpackage

// ===== sv/utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream, one byte per transfer, into UTF-16 code units.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, data_byte_i) takes one UTF-8
// byte per transfer. The output channel (out_valid_o, out_stall_i and the
// result fields) gives one UTF-16 code unit per transfer. A byte causes zero
// results (an unfinished sequence), one result, or two results (a surrogate
// pair, high unit first); last_of_run marks the final result of a byte.
// A byte taken sits in the input register, is decoded combinationally, and is
// written into the output register, whose result drives the output ports.
// Throughput is one byte per cycle while the receiver keeps up and no low
// surrogate is held. A surrogate pair fills the output register with the high
// unit and then the low unit; the low unit waits in a one-entry holding
// register, and the input stalls until it moves into the output register.
// A zero byte gives a terminator result and clears the decoder, dropping any
// partial character. Reset empties both registers and clears the decoder.
// When the receiver stalls, the output register holds its result; the input
// register still takes a byte as long as decoding it needs no output slot.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [u8u16_pkg::ByteW-1:0]      data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [u8u16_pkg::UnitW-1:0]      code_unit_o,
  output logic                             is_terminator_o,
  output logic                             bad_code_point_o,
  output logic                             last_of_run_o
);

  // Input register.
  logic                              in_vld_q;
  logic [u8u16_pkg::ByteW-1:0]       in_byte_q;

  // Decoder state: continuation bytes still owed and the partial code point.
  logic [u8u16_pkg::OwedW-1:0]       owed_q, owed_d;
  logic [u8u16_pkg::PointW-1:0]      partial_q, partial_d;

  // Output register and the holding register for a low surrogate.
  logic                              out_vld_q;
  u8u16_pkg::result_t                out_q;
  logic                              pend_vld_q;
  logic [u8u16_pkg::UnitW-1:0]       pend_unit_q;

  // Decode results.
  logic                              dec_emit;
  logic                              dec_term;
  logic [u8u16_pkg::PointW-1:0]      dec_cp;
  logic [u8u16_pkg::PointW-1:0]      acc_pt;
  logic [u8u16_pkg::PointW-1:0]      sup_off;
  logic                              cp_bad;
  logic                              cp_pair;
  u8u16_pkg::result_t                dec_first;
  logic [u8u16_pkg::UnitW-1:0]       dec_lo_unit;

  // Handshake control.
  logic                              out_ready;
  logic                              consume;

  // The partial point shifts left by six and takes the low six bits of the
  // continuation byte; the tag bits are ignored.
  assign acc_pt = {partial_q[u8u16_pkg::PointW-7:0], in_byte_q[5:0]};

  always_comb begin
    owed_d    = owed_q;
    partial_d = partial_q;
    dec_emit  = 1'b0;
    dec_term  = 1'b0;
    dec_cp    = '0;
    if (in_byte_q == '0) begin
      // A zero byte ends the string wherever it arrives.
      owed_d    = '0;
      partial_d = '0;
      dec_emit  = 1'b1;
      dec_term  = 1'b1;
    end else if (owed_q != '0) begin
      owed_d = owed_q - 2'd1;
      if (owed_d != '0) begin
        partial_d = acc_pt;
      end else begin
        partial_d = '0;
        dec_cp    = acc_pt;
        dec_emit  = 1'b1;
      end
    end else if (!in_byte_q[7]) begin
      dec_cp   = {13'd0, in_byte_q};
      dec_emit = 1'b1;
    end else if (in_byte_q[7:5] == u8u16_pkg::Lead2Tag) begin
      partial_d = {16'd0, in_byte_q[4:0]};
      owed_d    = 2'd1;
    end else if (in_byte_q[7:4] == u8u16_pkg::Lead3Tag) begin
      partial_d = {17'd0, in_byte_q[3:0]};
      owed_d    = 2'd2;
    end else if (in_byte_q[7:3] == u8u16_pkg::Lead4Tag) begin
      partial_d = {18'd0, in_byte_q[2:0]};
      owed_d    = 2'd3;
    end else begin
      // Stray continuation byte or an impossible lead byte: unit zero.
      dec_emit = 1'b1;
    end
  end

  // Code point classification. Terminators and bad lead bytes carry a zero
  // code point, which is neither bad nor a pair, so they come out as unit 0.
  assign cp_bad  = ((dec_cp >= u8u16_pkg::SurrLo) && (dec_cp <= u8u16_pkg::SurrHi)) ||
                   (dec_cp > u8u16_pkg::PointMax);
  assign cp_pair = !cp_bad && (dec_cp >= u8u16_pkg::SuppBase);
  assign sup_off = dec_cp - u8u16_pkg::SuppBase;

  always_comb begin
    dec_first.is_terminator  = dec_term;
    dec_first.bad_code_point = cp_bad;
    dec_first.last_of_run    = !cp_pair;
    if (cp_bad) begin
      dec_first.code_unit = '0;
    end else if (cp_pair) begin
      dec_first.code_unit = {u8u16_pkg::HiSurrTag, sup_off[19:10]};
    end else begin
      dec_first.code_unit = dec_cp[u8u16_pkg::UnitW-1:0];
    end
  end

  assign dec_lo_unit = {u8u16_pkg::LoSurrTag, sup_off[9:0]};

  // The output register can load when it is empty or being drained. A held
  // low surrogate goes first; until it leaves, the input register waits.
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign consume    = in_vld_q && !pend_vld_q && (!dec_emit || out_ready);
  assign in_stall_o = in_vld_q && !consume;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      owed_q     <= '0;
      partial_q  <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (consume) begin
        owed_q    <= owed_d;
        partial_q <= partial_d;
      end
      if (out_ready) begin
        if (pend_vld_q) begin
          out_vld_q  <= 1'b1;
          pend_vld_q <= 1'b0;
        end else if (consume && dec_emit) begin
          out_vld_q  <= 1'b1;
          pend_vld_q <= cp_pair;
        end else begin
          out_vld_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
    if (out_ready) begin
      if (pend_vld_q) begin
        out_q.code_unit      <= pend_unit_q;
        out_q.is_terminator  <= 1'b0;
        out_q.bad_code_point <= 1'b0;
        out_q.last_of_run    <= 1'b1;
      end else if (consume && dec_emit) begin
        out_q       <= dec_first;
        pend_unit_q <= dec_lo_unit;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign code_unit_o      = out_q.code_unit;
  assign is_terminator_o  = out_q.is_terminator;
  assign bad_code_point_o = out_q.bad_code_point;
  assign last_of_run_o    = out_q.last_of_run;

`ifndef SYNTH
  // A held low surrogate always has its high unit in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (out_vld_q && !out_q.last_of_run &&
                    (out_q.code_unit[15:10] == u8u16_pkg::HiSurrTag)))
    else $error("held low surrogate without a high surrogate in front");

  // No byte is decoded while a low surrogate is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> !consume)
    else $error("byte decoded ahead of a held low surrogate");

  // A bad code point or a terminator is a single zero unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.bad_code_point || out_q.is_terminator)) |->
      ((out_q.code_unit == '0) && out_q.last_of_run))
    else $error("error or terminator result is not a single zero unit");

  // A decoded zero byte leaves the decoder cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && dec_term) |=> ((owed_q == '0) && (partial_q == '0)))
    else $error("decoder state not cleared by terminator");
`endif

endmodule
